// ----- rtl/sorted_priority_queue_assert.svh -----
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [DataW-1:0] NEG_ONE = '1;

  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// Channel  Dir  tdata                                   tuser
// s_axis   in   value[31:0] priority_req[63:32]         action[1:0]
// m_axis   out  removed[31:0] count[36:32]              status[1:0]
//               front[68:37] rear[100:69]
// cfg      in   cfg_we_i / cfg_wdata_i = max_mode
//
// Each beat is first registered, then the sorted cell row is updated
// (parallel compare and shift of all CAPACITY cells).
// The result is offered in the cycle after the update.
// A waiting result holds off the input; the next beat is taken in the
// cycle the result leaves, and no beat is taken while a request executes.
// Reset empties the queue and clears max_mode.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,  // value, priority_req
  input  logic [1:0]   s_axis_tuser_i,  // action
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,  // removed_value, count, front_value, rear_value
  output logic [1:0]   m_axis_tuser_o   // status
);

  spq_pkg::spq_cmd_t cmd;
  logic [31:0] removed, front, rear;
  logic [4:0]  count;
  logic [1:0]  status;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (s_axis_tuser_i),
    .value_i         (s_axis_tdata_i[31:0]),
    .priority_i      (s_axis_tdata_i[63:32]),
    .removed_value_o (removed),
    .status_o        (status),
    .count_o         (count),
    .front_value_o   (front),
    .rear_value_o    (rear)
  );

  assign m_axis_tdata_o = {3'b000, rear, front, count, removed};
  assign m_axis_tuser_o = status;

  `include "sorted_priority_queue_assert.svh"

  `SPQ_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec && !s_axis_tready_o, "load not followed by exec")
  `SPQ_ASSERT_NEXT(a_exec_out, cmd.exec, m_axis_tvalid_o, "exec left no result")
  `SPQ_ASSERT_SAME(a_exec_free, cmd.exec, !cmd.load, "load during exec")
  `SPQ_ASSERT_SAME(a_empty_res, m_axis_tvalid_o && (status == spq_pkg::STAT_EMPTY), (removed == spq_pkg::NEG_ONE) && (front == spq_pkg::NEG_ONE), "empty delete result wrong")

endmodule

// ----- rtl/spq_ctrl.sv -----
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output spq_pkg::spq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   s_ready;

  assign s_ready = (state_q == ST_IDLE) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i && s_ready) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_ready_i) out_valid_d = 1'b0;
    if (state_q == ST_EXEC) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o  = s_ready;
  assign m_valid_o  = out_valid_q;
  assign cmd_o.load = s_valid_i && s_ready;
  assign cmd_o.exec = (state_q == ST_EXEC);

endmodule

// ----- rtl/spq_datapath.sv -----
module spq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::spq_cmd_t         cmd_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic [1:0]                action_i,
  input  logic [spq_pkg::DataW-1:0] value_i,
  input  logic [spq_pkg::DataW-1:0] priority_i,
  output logic [spq_pkg::DataW-1:0] removed_value_o,
  output logic [1:0]                status_o,
  output logic [4:0]                count_o,
  output logic [spq_pkg::DataW-1:0] front_value_o,
  output logic [spq_pkg::DataW-1:0] rear_value_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = spq_pkg::DataW;

  logic          max_mode_q;
  logic [1:0]    act_q;
  logic [DW-1:0] val_in_q, prio_in_q;

  logic [DW-1:0] prio_q [CAPACITY];
  logic [DW-1:0] val_q  [CAPACITY];
  logic [DW-1:0] prio_d [CAPACITY];
  logic [DW-1:0] val_d  [CAPACITY];
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] rear_q, rear_d;

  logic [DW-1:0] key;
  logic [CAPACITY-1:0] occ, le;
  logic full, empty;
  logic [DW-1:0] removed_d;
  logic [1:0]    status_d;

  logic [DW-1:0] removed_q, front_q, rear_out_q;
  logic [1:0]    status_q;
  logic [4:0]    count_out_q;

  assign key   = max_mode_q ? (DW'(0) - val_in_q) : prio_in_q;
  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  // occupied slots whose key does not exceed the new one; thermometer code
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CW'(i) < count_q);
      le[i]  = occ[i] && ($signed(prio_q[i]) <= $signed(key));
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      prio_d[i] = prio_q[i];
      val_d[i]  = val_q[i];
    end
    count_d   = count_q;
    rear_d    = rear_q;
    removed_d = '0;
    status_d  = spq_pkg::STAT_OK;
    case (act_q)
      spq_pkg::ACT_INSERT: begin
        if (full) begin
          status_d = spq_pkg::STAT_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!le[i]) begin
              if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
                prio_d[i] = key;
                val_d[i]  = val_in_q;
              end else begin
                prio_d[i] = prio_q[(i == 0) ? 0 : i-1];
                val_d[i]  = val_q[(i == 0) ? 0 : i-1];
              end
            end
          end
          if (le == occ) rear_d = val_in_q;
          count_d = count_q + CW'(1);
        end
      end
      spq_pkg::ACT_DELETE: begin
        if (empty) begin
          removed_d = spq_pkg::NEG_ONE;
          status_d  = spq_pkg::STAT_EMPTY;
        end else begin
          removed_d = val_q[0];
          for (int i = 0; i < CAPACITY - 1; i++) begin
            prio_d[i] = prio_q[i+1];
            val_d[i]  = val_q[i+1];
          end
          count_d = count_q - CW'(1);
        end
      end
      spq_pkg::ACT_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_mode_q <= 1'b0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) max_mode_q <= cfg_wdata_i;
      if (cmd_i.exec) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= action_i;
      val_in_q  <= value_i;
      prio_in_q <= priority_i;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        prio_q[i] <= prio_d[i];
        val_q[i]  <= val_d[i];
      end
      rear_q      <= rear_d;
      removed_q   <= removed_d;
      status_q    <= status_d;
      count_out_q <= 5'(count_d);
      front_q     <= (count_d == '0) ? spq_pkg::NEG_ONE : val_d[0];
      rear_out_q  <= (count_d == '0) ? spq_pkg::NEG_ONE : rear_d;
    end
  end

  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign count_o         = count_out_q;
  assign front_value_o   = front_q;
  assign rear_value_o    = rear_out_q;

endmodule
